[src/todau_pkg.sv]
// Shared types, constants and constant-table builders for the time-of-day adjust unit.
package todau_pkg;

  // Calendar constants
  localparam int DaySecs     = 86400;
  localparam int HourSecs    = 3600;
  localparam int MinSecs     = 60;
  localparam int MaxHour     = 23;
  localparam int MaxMinSec   = 59;
  localparam int HoursPerDay = 24;

  // Datapath widths: seconds of a day, sum of four table words, sum of twelve
  localparam int DayW      = 17;
  localparam int FieldSumW = 19;
  localparam int TotalW    = 20;
  localparam int RemW      = 12;
  // Largest multiple of a day that the twelve-word total can hold
  localparam int FoldMax   = 11;

  // Reciprocals for exact division by 3600 (below one day) and by 60 (below one hour)
  localparam int HourRecip      = 74566;
  localparam int HourRecipShift = 28;
  localparam int MinRecip       = 2185;
  localparam int MinRecipShift  = 17;

  typedef enum logic [1:0] {
    OP_CHECKED_SET = 2'd0,
    OP_NORM_SET    = 2'd1,
    OP_SHIFT       = 2'd2,
    OP_IDLE        = 2'd3
  } opcode_e;

  typedef logic [DayW-1:0] day_sec_t;
  typedef day_sec_t        byte_tab_t [256];
  typedef day_sec_t        hour_base_t [32];
  typedef logic [RemW-1:0] min_base_t [64];

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // Per-request control that rides along the pipeline
  typedef struct packed {
    opcode_e op;
    logic    ok;
    hms_t    load;
  } side_t;

  // Build the floor residue mod one day of (byte value * 2^(8*pos) * weight)
  function automatic byte_tab_t mod_tab(input int weight, input int pos, input bit top);
    byte_tab_t tab;
    longint    v;
    longint    r;
    for (int i = 0; i < 256; i++) begin
      v = longint'(i);
      if (top && (i >= 128)) begin
        v = v - 256;
      end
      v = v * longint'(weight) * (longint'(1) <<< (8 * pos));
      r = v % DaySecs;
      if (r < 0) begin
        r = r + DaySecs;
      end
      tab[i] = DayW'(r);
    end
    return tab;
  endfunction

  // Build the seconds at the start of each hour
  function automatic hour_base_t hour_base();
    hour_base_t tab;
    for (int i = 0; i < 32; i++) begin
      tab[i] = (i < HoursPerDay) ? DayW'(i * HourSecs) : '0;
    end
    return tab;
  endfunction

  // Build the seconds at the start of each minute
  function automatic min_base_t min_base();
    min_base_t tab;
    for (int i = 0; i < 64; i++) begin
      tab[i] = (i < MinSecs) ? RemW'(i * MinSecs) : '0;
    end
    return tab;
  endfunction

endpackage

[src/todau_req_if.sv]
// Request channel of the time-of-day adjust unit.
interface todau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] hour_value;
  logic signed [31:0] minute_value;
  logic signed [31:0] second_value;
  logic signed [31:0] shift_seconds;

  modport source (
    output valid, opcode, hour_value, minute_value, second_value, shift_seconds,
    input  ready
  );
  modport sink (
    input  valid, opcode, hour_value, minute_value, second_value, shift_seconds,
    output ready
  );
endinterface

[src/todau_res_if.sv]
// Result channel of the time-of-day adjust unit.
interface todau_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic       invalid_time;

  modport source (
    output valid, hour_out, minute_out, second_out, invalid_time,
    input  ready
  );
  modport sink (
    input  valid, hour_out, minute_out, second_out, invalid_time,
    output ready
  );
endinterface

[src/time_of_day_adjust_unit_core.sv]
// Top level of the time-of-day adjust unit: reduce, split and update pipeline.
//
// Holds a 24-hour time (hh:mm:ss, reset to 00:00:00) and answers every request
// with the time after it: a checked set loads in-range values or flags
// invalid_time and keeps the time, a normalized set loads any signed h/m/s
// folded modulo one day, a shift adds signed seconds, and opcode 3 only reads.
// The unit takes one request per clock while no stall holds it. The operand path
// holds byte residue tables, a fold below one day, and two reciprocal multiplies
// that split the day offset into digits. Only the last stage touches the held
// time, with a carry add, so back-to-back shifts see each other. Stalls move back
// stage by stage and empty stages keep filling while a result waits.
module time_of_day_adjust_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  todau_req_if.sink   req_i,
  todau_res_if.source res_o
);

  logic                red_valid, red_ready;
  todau_pkg::day_sec_t red_day;
  todau_pkg::side_t    red_side;

  logic                spl_valid, spl_ready;
  todau_pkg::hms_t     spl_hms;
  todau_pkg::side_t    spl_side;

  todau_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (red_valid),
    .ready_i (red_ready),
    .day_o   (red_day),
    .side_o  (red_side)
  );

  todau_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (red_valid),
    .ready_o (red_ready),
    .day_i   (red_day),
    .side_i  (red_side),
    .valid_o (spl_valid),
    .ready_i (spl_ready),
    .hms_o   (spl_hms),
    .side_o  (spl_side)
  );

  todau_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (spl_valid),
    .ready_o (spl_ready),
    .hms_i   (spl_hms),
    .side_i  (spl_side),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  // Folded offset stays below one day
  a_fold_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_valid |-> (red_day < todau_pkg::DayW'(todau_pkg::DaySecs)))
    else $error("folded offset not below one day");

  // Results always carry a legal time
  a_time_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.hour_out <= 5'(todau_pkg::MaxHour))
                  && (res_o.minute_out <= 6'(todau_pkg::MaxMinSec))
                  && (res_o.second_out <= 6'(todau_pkg::MaxMinSec))))
    else $error("result time out of range");

  // A rejected checked set flags and keeps the time
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spl_valid && spl_ready && (spl_side.op == todau_pkg::OP_CHECKED_SET) && !spl_side.ok)
    |=> (res_o.invalid_time && $stable(res_o.hour_out) && $stable(res_o.minute_out)
         && $stable(res_o.second_out)))
    else $error("rejected set changed the time or lost the flag");

  // Only a checked set may raise the flag
  a_flag_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spl_valid && spl_ready && (spl_side.op != todau_pkg::OP_CHECKED_SET))
    |=> !res_o.invalid_time)
    else $error("invalid_time raised by a request other than a checked set");
`endif

endmodule

[src/todau_reduce.sv]
// Request register and table-based reduction of the operand seconds modulo one day.
module todau_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  todau_req_if.sink           req_i,
  output logic                valid_o,
  input  logic                ready_i,
  output todau_pkg::day_sec_t day_o,
  output todau_pkg::side_t    side_o
);

  // Residue tables, one per field weight and byte position; top byte is signed
  localparam todau_pkg::byte_tab_t HourTab0 = todau_pkg::mod_tab(todau_pkg::HourSecs, 0, 1'b0);
  localparam todau_pkg::byte_tab_t HourTab1 = todau_pkg::mod_tab(todau_pkg::HourSecs, 1, 1'b0);
  localparam todau_pkg::byte_tab_t HourTab2 = todau_pkg::mod_tab(todau_pkg::HourSecs, 2, 1'b0);
  localparam todau_pkg::byte_tab_t HourTab3 = todau_pkg::mod_tab(todau_pkg::HourSecs, 3, 1'b1);
  localparam todau_pkg::byte_tab_t MinTab0  = todau_pkg::mod_tab(todau_pkg::MinSecs, 0, 1'b0);
  localparam todau_pkg::byte_tab_t MinTab1  = todau_pkg::mod_tab(todau_pkg::MinSecs, 1, 1'b0);
  localparam todau_pkg::byte_tab_t MinTab2  = todau_pkg::mod_tab(todau_pkg::MinSecs, 2, 1'b0);
  localparam todau_pkg::byte_tab_t MinTab3  = todau_pkg::mod_tab(todau_pkg::MinSecs, 3, 1'b1);
  localparam todau_pkg::byte_tab_t SecTab0  = todau_pkg::mod_tab(1, 0, 1'b0);
  localparam todau_pkg::byte_tab_t SecTab1  = todau_pkg::mod_tab(1, 1, 1'b0);
  localparam todau_pkg::byte_tab_t SecTab2  = todau_pkg::mod_tab(1, 2, 1'b0);
  localparam todau_pkg::byte_tab_t SecTab3  = todau_pkg::mod_tab(1, 3, 1'b1);

  localparam int FsW = todau_pkg::FieldSumW;
  localparam int TtW = todau_pkg::TotalW;

  logic [3:0] vld_q;
  logic [3:0] adv;

  // Stage 1: request register
  todau_pkg::opcode_e op1_q;
  logic signed [31:0] hour1_q, min1_q, sec1_q, shift1_q;

  // Stage 2: per-field residue sums
  logic signed [31:0] hour_sel, min_sel, sec_sel;
  logic [FsW-1:0]     hsum_d, msum_d, ssum_d;
  logic [FsW-1:0]     hsum_q, msum_q, ssum_q;
  todau_pkg::side_t   side2_d, side2_q;

  // Stage 3: grand total
  logic [TtW-1:0]     tot_d, tot_q;
  todau_pkg::side_t   side3_q;

  // Stage 4: folded seconds of the day
  todau_pkg::day_sec_t day_d, day_q;
  todau_pkg::side_t    side4_q;

  // Advance a stage when it is empty or its successor advances
  assign adv[3] = !vld_q[3] || ready_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign req_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < 4; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (adv[0] && req_i.valid) begin
      op1_q    <= todau_pkg::opcode_e'(req_i.opcode);
      hour1_q  <= req_i.hour_value;
      min1_q   <= req_i.minute_value;
      sec1_q   <= req_i.second_value;
      shift1_q <= req_i.shift_seconds;
    end
  end

  // Route the shift amount into the seconds slot; look up byte residues
  always_comb begin
    hour_sel = (op1_q == todau_pkg::OP_SHIFT) ? 32'sd0 : hour1_q;
    min_sel  = (op1_q == todau_pkg::OP_SHIFT) ? 32'sd0 : min1_q;
    sec_sel  = (op1_q == todau_pkg::OP_SHIFT) ? shift1_q : sec1_q;
    hsum_d = FsW'(HourTab0[hour_sel[7:0]]) + FsW'(HourTab1[hour_sel[15:8]])
           + FsW'(HourTab2[hour_sel[23:16]]) + FsW'(HourTab3[hour_sel[31:24]]);
    msum_d = FsW'(MinTab0[min_sel[7:0]]) + FsW'(MinTab1[min_sel[15:8]])
           + FsW'(MinTab2[min_sel[23:16]]) + FsW'(MinTab3[min_sel[31:24]]);
    ssum_d = FsW'(SecTab0[sec_sel[7:0]]) + FsW'(SecTab1[sec_sel[15:8]])
           + FsW'(SecTab2[sec_sel[23:16]]) + FsW'(SecTab3[sec_sel[31:24]]);
    // Range check for the checked set
    side2_d.op = op1_q;
    side2_d.ok = !hour1_q[31] && (hour1_q[30:0] <= 31'(todau_pkg::MaxHour))
              && !min1_q[31] && (min1_q[30:0] <= 31'(todau_pkg::MaxMinSec))
              && !sec1_q[31] && (sec1_q[30:0] <= 31'(todau_pkg::MaxMinSec));
    side2_d.load.hour   = hour1_q[4:0];
    side2_d.load.minute = min1_q[5:0];
    side2_d.load.second = sec1_q[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      hsum_q  <= hsum_d;
      msum_q  <= msum_d;
      ssum_q  <= ssum_d;
      side2_q <= side2_d;
    end
  end

  // Add the three field sums
  assign tot_d = TtW'(hsum_q) + TtW'(msum_q) + TtW'(ssum_q);

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      tot_q   <= tot_d;
      side3_q <= side2_q;
    end
  end

  // Fold the total below one day: subtract the largest multiple that fits
  always_comb begin
    day_d = todau_pkg::DayW'(tot_q);
    for (int j = 1; j <= todau_pkg::FoldMax; j++) begin
      if (tot_q >= TtW'(j * todau_pkg::DaySecs)) begin
        day_d = todau_pkg::DayW'(tot_q - TtW'(j * todau_pkg::DaySecs));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      day_q   <= day_d;
      side4_q <= side3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign day_o   = day_q;
  assign side_o  = side4_q;

endmodule

[src/todau_split.sv]
// Split of seconds of the day into hour, minute and second digits.
module todau_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  todau_pkg::day_sec_t day_i,
  input  todau_pkg::side_t    side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output todau_pkg::hms_t     hms_o,
  output todau_pkg::side_t    side_o
);

  localparam todau_pkg::hour_base_t HourBase = todau_pkg::hour_base();
  localparam todau_pkg::min_base_t  MinBase  = todau_pkg::min_base();
  localparam int DW = todau_pkg::DayW;
  localparam int RW = todau_pkg::RemW;
  localparam int HourProdW = 2 * DW;
  localparam int MinProdW  = 2 * RW;

  logic [2:0] vld_q;
  logic [2:0] adv;

  // Stage 5: hour digit
  logic [HourProdW-1:0] hour_prod;
  todau_pkg::day_sec_t  day5_q;
  logic [4:0]           hour5_q;
  todau_pkg::side_t     side5_q;

  // Stage 6: minute digit and seconds into the hour
  logic [RW-1:0]        rem_d;
  logic [MinProdW-1:0]  min_prod;
  logic [RW-1:0]        rem6_q;
  logic [4:0]           hour6_q;
  logic [5:0]           min6_q;
  todau_pkg::side_t     side6_q;

  // Stage 7: second digit
  todau_pkg::hms_t      hms_d, hms7_q;
  todau_pkg::side_t     side7_q;

  assign adv[2] = !vld_q[2] || ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < 3; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Divide by 3600 through the reciprocal
  assign hour_prod = HourProdW'(day_i) * HourProdW'(todau_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      day5_q  <= day_i;
      hour5_q <= hour_prod[todau_pkg::HourRecipShift +: 5];
      side5_q <= side_i;
    end
  end

  // Take off the whole hours, then divide the rest by 60
  assign rem_d    = RW'(day5_q - HourBase[hour5_q]);
  assign min_prod = MinProdW'(rem_d) * MinProdW'(todau_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      rem6_q  <= rem_d;
      hour6_q <= hour5_q;
      min6_q  <= min_prod[todau_pkg::MinRecipShift +: 6];
      side6_q <= side5_q;
    end
  end

  // Take off the whole minutes
  always_comb begin
    hms_d.hour   = hour6_q;
    hms_d.minute = min6_q;
    hms_d.second = 6'(rem6_q - MinBase[min6_q]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      hms7_q  <= hms_d;
      side7_q <= side6_q;
    end
  end

  assign valid_o = vld_q[2];
  assign hms_o   = hms7_q;
  assign side_o  = side7_q;

endmodule

[src/todau_update.sv]
// Time register update and result register of the time-of-day adjust unit.
module todau_update (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  todau_pkg::hms_t  hms_i,
  input  todau_pkg::side_t side_i,
  todau_res_if.source      res_o
);

  // The result register doubles as the held time: it only changes when the
  // previous result has left, and every result is the time after its request.
  logic            vld_q;
  logic            adv;
  todau_pkg::hms_t time_d, time_q;
  logic            bad_d, bad_q;

  logic [6:0] sec_sum, min_sum;
  logic [5:0] hour_sum;
  logic       sec_carry, min_carry;
  logic [5:0] sec_new, min_new;
  logic [4:0] hour_new;

  assign adv     = !vld_q || res_o.ready;
  assign ready_o = adv;

  // Add the day offset to the held time with digit carries
  always_comb begin
    sec_sum   = 7'(time_q.second) + 7'(hms_i.second);
    sec_carry = sec_sum >= 7'(todau_pkg::MinSecs);
    sec_new   = sec_carry ? 6'(sec_sum - 7'(todau_pkg::MinSecs)) : 6'(sec_sum);
    min_sum   = 7'(time_q.minute) + 7'(hms_i.minute) + 7'(sec_carry);
    min_carry = min_sum >= 7'(todau_pkg::MinSecs);
    min_new   = min_carry ? 6'(min_sum - 7'(todau_pkg::MinSecs)) : 6'(min_sum);
    hour_sum  = 6'(time_q.hour) + 6'(hms_i.hour) + 6'(min_carry);
    hour_new  = (hour_sum >= 6'(todau_pkg::HoursPerDay))
              ? 5'(hour_sum - 6'(todau_pkg::HoursPerDay)) : 5'(hour_sum);
  end

  // Pick the next time by opcode
  always_comb begin
    time_d = time_q;
    bad_d  = 1'b0;
    case (side_i.op)
      todau_pkg::OP_CHECKED_SET: begin
        if (side_i.ok) begin
          time_d = side_i.load;
        end else begin
          bad_d = 1'b1;
        end
      end
      todau_pkg::OP_NORM_SET: begin
        time_d = hms_i;
      end
      todau_pkg::OP_SHIFT: begin
        time_d.hour   = hour_new;
        time_d.minute = min_new;
        time_d.second = sec_new;
      end
      default: begin
        time_d = time_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      time_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= valid_i;
      end
      if (adv && valid_i) begin
        time_q <= time_d;
        bad_q  <= bad_d;
      end
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.hour_out     = time_q.hour;
  assign res_o.minute_out   = time_q.minute;
  assign res_o.second_out   = time_q.second;
  assign res_o.invalid_time = bad_q;

endmodule
